// ===== design/fbcrc_pkg.sv =====
package fbcrc_pkg;

   localparam logic [7:0]  HEADER_BYTES      = 8'd3;
   localparam logic [7:0]  FOOTER_BYTES      = 8'd2;
   localparam logic [7:0]  DELIM0_ADDR       = 8'd0;
   localparam logic [7:0]  DELIM1_ADDR       = 8'd1;
   localparam logic [7:0]  SIZE_BYTE_ADDR    = 8'd2;
   localparam logic [15:0] CRC_INIT          = 16'hFFFF;
   localparam logic [15:0] CRC_POLY          = 16'hA001;
   localparam logic [7:0]  RESET_FIRST_DELIM = 8'h00;
   localparam logic [7:0]  RESET_SECOND_DELIM = 8'h00;
   localparam logic [7:0]  RESET_MAX_FRAME   = 8'hFF;
   localparam logic [7:0]  RESET_MAX_CHUNK   = 8'hFF;
   localparam int          QUEUE_DEPTH       = 4;

   typedef enum logic [1:0] {
      OP_START  = 2'd0,
      OP_CHUNK  = 2'd1,
      OP_DATA   = 2'd2,
      OP_FINISH = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_TOO_LONG = 2'd1,
      ST_NO_ROOM  = 2'd2,
      ST_NO_FRAME = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CSR_FIRST_DELIM  = 2'd0,
      CSR_SECOND_DELIM = 2'd1,
      CSR_MAX_FRAME    = 2'd2,
      CSR_MAX_CHUNK    = 2'd3
   } csr_index_type;

   // One queued command; multi marks a three-write sequence whose last write
   // goes to the size byte.
   typedef struct packed {
      logic       multi;
      status_type status;
      logic       write_valid;
      logic [7:0] addr0;
      logic [7:0] val0;
      logic [7:0] addr1;
      logic [7:0] val1;
      logic [7:0] val2;
      logic [7:0] byte_count;
      logic [7:0] room_left;
   } desc_type;

   function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ===== design/fbcrc_front.sv =====
module fbcrc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [1:0]           op,
   input  logic [7:0]           chunk_length,
   input  logic [7:0]           data_byte,
   input  logic                 csr_write,
   input  logic [1:0]           csr_index,
   input  logic [7:0]           csr_wdata,
   output fbcrc_pkg::desc_type  desc
);

   logic [7:0]  first_delim_ff, second_delim_ff, max_frame_ff, max_chunk_ff;
   logic [7:0]  wr_index_ff, wr_index_in;
   logic [15:0] crc_ff, crc_in;
   logic        frame_open_ff, frame_open_in;
   logic [7:0]  chunk_left_ff, chunk_left_in;
   logic        chunk_acc_ff, chunk_acc_in;
   logic [15:0] crc_next;
   logic [9:0]  chunk_end;
   logic [9:0]  room_diff;
   logic [7:0]  total;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_delim_ff  <= fbcrc_pkg::RESET_FIRST_DELIM;
         second_delim_ff <= fbcrc_pkg::RESET_SECOND_DELIM;
         max_frame_ff    <= fbcrc_pkg::RESET_MAX_FRAME;
         max_chunk_ff    <= fbcrc_pkg::RESET_MAX_CHUNK;
      end else if (csr_write) begin
         unique case (fbcrc_pkg::csr_index_type'(csr_index))
            fbcrc_pkg::CSR_FIRST_DELIM:  first_delim_ff  <= csr_wdata;
            fbcrc_pkg::CSR_SECOND_DELIM: second_delim_ff <= csr_wdata;
            fbcrc_pkg::CSR_MAX_FRAME:    max_frame_ff    <= csr_wdata;
            fbcrc_pkg::CSR_MAX_CHUNK:    max_chunk_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_index_ff   <= '0;
         crc_ff        <= fbcrc_pkg::CRC_INIT;
         frame_open_ff <= 1'b0;
         chunk_left_ff <= '0;
         chunk_acc_ff  <= 1'b0;
      end else begin
         wr_index_ff   <= wr_index_in;
         crc_ff        <= crc_in;
         frame_open_ff <= frame_open_in;
         chunk_left_ff <= chunk_left_in;
         chunk_acc_ff  <= chunk_acc_in;
      end
   end

   assign crc_next  = fbcrc_pkg::crc_fold(crc_ff, data_byte);
   assign chunk_end = {2'b00, wr_index_ff} + {2'b00, chunk_length}
                      + {2'b00, fbcrc_pkg::FOOTER_BYTES};
   assign total     = wr_index_ff + fbcrc_pkg::FOOTER_BYTES;

   always_comb begin
      wr_index_in   = wr_index_ff;
      crc_in        = crc_ff;
      frame_open_in = frame_open_ff;
      chunk_left_in = chunk_left_ff;
      chunk_acc_in  = chunk_acc_ff;
      desc          = '0;
      desc.status   = fbcrc_pkg::ST_OK;
      if (accept) begin
         unique case (fbcrc_pkg::op_type'(op))
            fbcrc_pkg::OP_START: begin
               wr_index_in   = fbcrc_pkg::HEADER_BYTES;
               crc_in        = fbcrc_pkg::CRC_INIT;
               frame_open_in = 1'b1;
               chunk_left_in = '0;
               chunk_acc_in  = 1'b0;
               desc.multi    = 1'b1;
               desc.addr0    = fbcrc_pkg::DELIM0_ADDR;
               desc.val0     = first_delim_ff;
               desc.addr1    = fbcrc_pkg::DELIM1_ADDR;
               desc.val1     = second_delim_ff;
            end
            fbcrc_pkg::OP_CHUNK: begin
               if (!frame_open_ff) begin
                  desc.status = fbcrc_pkg::ST_NO_FRAME;
               end else begin
                  chunk_left_in = '0;
                  chunk_acc_in  = 1'b0;
                  priority if (chunk_length > max_chunk_ff) begin
                     desc.status = fbcrc_pkg::ST_TOO_LONG;
                  end else if (chunk_end > {2'b00, max_frame_ff}) begin
                     desc.status = fbcrc_pkg::ST_NO_ROOM;
                  end else begin
                     chunk_left_in   = chunk_length;
                     chunk_acc_in    = 1'b1;
                     desc.byte_count = chunk_length;
                  end
               end
            end
            fbcrc_pkg::OP_DATA: begin
               if (!frame_open_ff || !chunk_acc_ff || chunk_left_ff == 8'd0) begin
                  desc.status = fbcrc_pkg::ST_NO_FRAME;
               end else begin
                  desc.write_valid = 1'b1;
                  desc.addr0       = wr_index_ff;
                  desc.val0        = data_byte;
                  crc_in           = crc_next;
                  wr_index_in      = wr_index_ff + 8'd1;
                  chunk_left_in    = chunk_left_ff - 8'd1;
                  if (chunk_left_ff == 8'd1) begin
                     chunk_acc_in = 1'b0;
                  end
               end
            end
            fbcrc_pkg::OP_FINISH: begin
               if (!frame_open_ff) begin
                  desc.status = fbcrc_pkg::ST_NO_FRAME;
               end else begin
                  desc.multi      = 1'b1;
                  desc.addr0      = wr_index_ff;
                  desc.val0       = crc_ff[7:0];
                  desc.addr1      = wr_index_ff + 8'd1;
                  desc.val1       = crc_ff[15:8];
                  desc.val2       = total;
                  desc.byte_count = total;
                  wr_index_in     = total;
                  frame_open_in   = 1'b0;
                  chunk_left_in   = '0;
                  chunk_acc_in    = 1'b0;
               end
            end
            default: ;
         endcase
      end
      room_diff      = {2'b00, max_frame_ff} - {2'b00, wr_index_in}
                       - {2'b00, fbcrc_pkg::FOOTER_BYTES};
      desc.room_left = room_diff[9] ? 8'd0 : room_diff[7:0];
   end

endmodule

// ===== design/fbcrc_queue.sv =====
module fbcrc_queue #(
   parameter int DEPTH = fbcrc_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  fbcrc_pkg::desc_type  push_desc,
   input  logic                 pop,
   output logic                 full,
   output logic                 empty,
   output fbcrc_pkg::desc_type  head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   fbcrc_pkg::desc_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

// ===== design/fbcrc_back.sv =====
module fbcrc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  fbcrc_pkg::desc_type  q_head,
   output logic                 q_pop,
   input  logic                 out_pop,
   output logic                 out_valid,
   output logic [1:0]           status,
   output logic                 write_valid,
   output logic [7:0]           write_address,
   output logic [7:0]           write_value,
   output logic [7:0]           byte_count,
   output logic [7:0]           room_left,
   output logic                 last
);

   localparam logic [1:0] LAST_PHASE = 2'd2;

   logic       out_valid_ff, out_valid_in;
   logic [1:0] phase_ff, phase_in;
   logic [1:0] status_ff, status_in;
   logic       wv_ff, wv_in;
   logic [7:0] addr_ff, addr_in;
   logic [7:0] value_ff, value_in;
   logic [7:0] count_ff, count_in;
   logic [7:0] room_ff, room_in;
   logic       last_ff, last_in;
   logic       advance;

   assign advance = !q_empty && (!out_valid_ff || out_pop);

   always_comb begin
      out_valid_in = out_valid_ff && !out_pop;
      phase_in     = phase_ff;
      q_pop        = 1'b0;
      status_in    = q_head.status;
      wv_in        = q_head.write_valid;
      addr_in      = q_head.addr0;
      value_in     = q_head.val0;
      count_in     = q_head.byte_count;
      room_in      = q_head.room_left;
      last_in      = 1'b1;
      if (q_head.multi) begin
         wv_in   = 1'b1;
         last_in = (phase_ff == LAST_PHASE);
         unique case (phase_ff)
            2'd0: begin
               addr_in  = q_head.addr0;
               value_in = q_head.val0;
            end
            2'd1: begin
               addr_in  = q_head.addr1;
               value_in = q_head.val1;
            end
            default: begin
               addr_in  = fbcrc_pkg::SIZE_BYTE_ADDR;
               value_in = q_head.val2;
            end
         endcase
      end
      if (advance) begin
         out_valid_in = 1'b1;
         if (last_in) begin
            phase_in = '0;
            q_pop    = 1'b1;
         end else begin
            phase_in = phase_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         phase_ff     <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         status_ff <= status_in;
         wv_ff     <= wv_in;
         addr_ff   <= addr_in;
         value_ff  <= value_in;
         count_ff  <= count_in;
         room_ff   <= room_in;
         last_ff   <= last_in;
      end
   end

   assign out_valid     = out_valid_ff;
   assign status        = status_ff;
   assign write_valid   = wv_ff;
   assign write_address = addr_ff;
   assign write_value   = value_ff;
   assign byte_count    = count_ff;
   assign room_left     = room_ff;
   assign last          = last_ff;

endmodule

// ===== design/frame_builder_crc16_core.sv =====
// Channel  | Direction | Transfer when           | Payload
// ---------+-----------+-------------------------+------------------------------------------
// req      | in        | push && !full           | req_op, req_chunk_length, req_data_byte
// rsp      | out       | pop && !empty           | rsp_status .. rsp_last (7 fields)
// csr      | in        | csr_valid && csr_ready  | csr_index, csr_wdata
//
// One command is taken per cycle unless full; the front updates frame state and the CRC.
// Start, and finish in an open frame, give three results, all others one; the back delivers
// one result a cycle unless rsp stalls. Results pass the queue and the output register.
// full rises when QUEUE_DEPTH commands wait in the queue ahead of the back.
// Synchronous reset clears frame state, queue and out_valid, and presets the registers.
module frame_builder_crc16_core #(
   parameter int QUEUE_DEPTH = fbcrc_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [1:0] req_op,
   input  logic [7:0] req_chunk_length,
   input  logic [7:0] req_data_byte,
   output logic       empty,
   input  logic       pop,
   output logic [1:0] rsp_status,
   output logic       rsp_write_valid,
   output logic [7:0] rsp_write_address,
   output logic [7:0] rsp_write_value,
   output logic [7:0] rsp_byte_count,
   output logic [7:0] rsp_room_left,
   output logic       rsp_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   fbcrc_pkg::desc_type front_desc;
   fbcrc_pkg::desc_type q_head;
   logic q_full, q_empty, q_pop, accept, out_valid;

   assign csr_ready = 1'b1;
   assign full      = q_full;
   assign accept    = push && !q_full;
   assign empty     = !out_valid;

   fbcrc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .op           (req_op),
      .chunk_length (req_chunk_length),
      .data_byte    (req_data_byte),
      .csr_write    (csr_valid && csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .desc         (front_desc)
   );

   fbcrc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_desc (front_desc),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   fbcrc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .out_pop       (pop),
      .out_valid     (out_valid),
      .status        (rsp_status),
      .write_valid   (rsp_write_valid),
      .write_address (rsp_write_address),
      .write_value   (rsp_write_value),
      .byte_count    (rsp_byte_count),
      .room_left     (rsp_room_left),
      .last          (rsp_last)
   );

endmodule

// ===== design/fbcrc_checker.sv =====
module fbcrc_checker (
   input logic       clock,
   input logic       reset,
   input logic       empty,
   input logic       pop,
   input logic [1:0] rsp_status,
   input logic       rsp_write_valid,
   input logic [7:0] rsp_write_address,
   input logic [7:0] rsp_write_value,
   input logic [7:0] rsp_byte_count,
   input logic       rsp_last
);

   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result pending right after reset");

   a_idle_write_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_write_valid) |-> (rsp_write_address == 8'd0 && rsp_write_value == 8'd0))
      else $error("address or value set on a result without a write");

   a_error_single: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_status != fbcrc_pkg::ST_OK) |->
         (!rsp_write_valid && rsp_last && rsp_byte_count == 8'd0))
      else $error("error result carries a write, a count or is not last");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_status) && $stable(rsp_write_address)
         && $stable(rsp_write_value) && $stable(rsp_last)))
      else $error("stalled result changed");

endmodule

bind frame_builder_crc16_core fbcrc_checker u_fbcrc_checker (.*);
